FILE: sv/epf_pkg.sv
// package: word types, register map, sequencer control words and program rom
`default_nettype none
package epf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned COUNT_W  = 2;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned SEL_W    = 3;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'h17;
    localparam logic [BYTE_W-1:0] STOP_RESET   = 8'h30;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

    typedef enum logic [1:0] {
        REG_START  = 2'd0,
        REG_STOP   = 2'd1,
        REG_ESCAPE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0]         address;
        logic [COUNT_W-1:0]        value_count;
        logic signed [VALUE_W-1:0] value_first;
        logic signed [VALUE_W-1:0] value_second;
        logic signed [VALUE_W-1:0] value_third;
    } req_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              frame_end;
    } line_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] stop_marker;
        logic [BYTE_W-1:0] escape_marker;
    } markers_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_START = 4'd0;
    localparam step_t STEP_ADDR  = 4'd1;
    localparam step_t STEP_V0_LO = 4'd2;
    localparam step_t STEP_V0_HI = 4'd3;
    localparam step_t STEP_V1_LO = 4'd4;
    localparam step_t STEP_V1_HI = 4'd5;
    localparam step_t STEP_V2_LO = 4'd6;
    localparam step_t STEP_V2_HI = 4'd7;
    localparam step_t STEP_STOP  = 4'd8;

    typedef enum logic [1:0] {
        SRC_START,
        SRC_BODY,
        SRC_STOP
    } src_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_ADDR,
        SEL_V0_LO,
        SEL_V0_HI,
        SEL_V1_LO,
        SEL_V1_HI,
        SEL_V2_LO,
        SEL_V2_HI
    } sel_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_CNT_LT1,
        JMP_CNT_LT2,
        JMP_CNT_LT3
    } jmp_t;

    typedef struct packed {
        src_t  src;
        sel_t  sel;
        logic  esc_chk;
        logic  last;
        jmp_t  jmp;
        step_t target;
        step_t next;
    } ctrl_t;

    function automatic ctrl_t rom_word(input step_t s);
        ctrl_t w;
        w = '{src: SRC_STOP, sel: SEL_ADDR, esc_chk: 1'b0, last: 1'b1,
              jmp: JMP_NONE, target: STEP_START, next: STEP_START};
        case (s)
            STEP_START: w = '{SRC_START, SEL_ADDR, 1'b0, 1'b0, JMP_NONE,
                              STEP_STOP, STEP_ADDR};
            STEP_ADDR:  w = '{SRC_BODY, SEL_ADDR, 1'b1, 1'b0, JMP_CNT_LT1,
                              STEP_STOP, STEP_V0_LO};
            STEP_V0_LO: w = '{SRC_BODY, SEL_V0_LO, 1'b1, 1'b0, JMP_NONE,
                              STEP_STOP, STEP_V0_HI};
            STEP_V0_HI: w = '{SRC_BODY, SEL_V0_HI, 1'b1, 1'b0, JMP_CNT_LT2,
                              STEP_STOP, STEP_V1_LO};
            STEP_V1_LO: w = '{SRC_BODY, SEL_V1_LO, 1'b1, 1'b0, JMP_NONE,
                              STEP_STOP, STEP_V1_HI};
            STEP_V1_HI: w = '{SRC_BODY, SEL_V1_HI, 1'b1, 1'b0, JMP_CNT_LT3,
                              STEP_STOP, STEP_V2_LO};
            STEP_V2_LO: w = '{SRC_BODY, SEL_V2_LO, 1'b1, 1'b0, JMP_NONE,
                              STEP_STOP, STEP_V2_HI};
            STEP_V2_HI: w = '{SRC_BODY, SEL_V2_HI, 1'b1, 1'b0, JMP_NONE,
                              STEP_STOP, STEP_STOP};
            STEP_STOP:  w = '{SRC_STOP, SEL_ADDR, 1'b0, 1'b1, JMP_NONE,
                              STEP_START, STEP_START};
            default:    w = '{SRC_STOP, SEL_ADDR, 1'b0, 1'b1, JMP_NONE,
                              STEP_START, STEP_START};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: sv/escaped_packet_framer_unit.sv
// top level: marker registers on the apb port and the frame sequencer
//
//  channel   dir   handshake                     word
//  req       in    req_valid / req_ready         req_word (req_word_t)
//  line      out   line_valid / line_ready       line_word (line_word_t)
//  cfg       in    psel penable pwrite pready    paddr / pwdata / prdata
//
// one line word per cycle while line_ready is high; a frame is 3 to 16 words
// the sequencer steps its program once per frame word; an escape word holds the step
// the next request is taken once the stop word is in the output register
// line_ready low while a word is held holds the output register and the program step
// reset loads the marker defaults and leaves the sequencer idle
`default_nettype none
module escaped_packet_framer_unit
    import epf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire req_word_t         req_word,
    output logic                   line_valid,
    input  wire logic              line_ready,
    output line_word_t             line_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    markers_t markers_reg, markers_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        markers_next = markers_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START:  markers_next.start_marker  = pwdata[BYTE_W-1:0];
                REG_STOP:   markers_next.stop_marker   = pwdata[BYTE_W-1:0];
                REG_ESCAPE: markers_next.escape_marker = pwdata[BYTE_W-1:0];
                default:    markers_next = markers_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START:  prdata = {{(DATA_W-BYTE_W){1'b0}}, markers_reg.start_marker};
            REG_STOP:   prdata = {{(DATA_W-BYTE_W){1'b0}}, markers_reg.stop_marker};
            REG_ESCAPE: prdata = {{(DATA_W-BYTE_W){1'b0}}, markers_reg.escape_marker};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            markers_reg <= '{start_marker: START_RESET, stop_marker: STOP_RESET,
                             escape_marker: ESCAPE_RESET};
        end
        else
        begin
            markers_reg <= markers_next;
        end
    end

    epf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .markers    (markers_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_word   (req_word),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_word  (line_word)
    );

endmodule
`default_nettype wire

FILE: sv/epf_seq.sv
// microcoded frame sequencer: request capture, program rom, byte datapath, output register
`default_nettype none
module epf_seq
    import epf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire markers_t   markers,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_word_t  req_word,
    output logic            line_valid,
    input  wire logic       line_ready,
    output line_word_t      line_word
);

    logic       busy_reg,   busy_next;
    step_t      step_reg,   step_next;
    logic       esc_reg,    esc_next;
    logic       valid_reg,  valid_next;
    line_word_t word_reg,   word_next;
    req_word_t  req_reg;

    ctrl_t             cw;
    logic [BYTE_W-1:0] body_byte;
    logic [BYTE_W-1:0] src_byte;
    logic              reserved;
    logic              take_jump;
    logic              advance;
    logic              req_take;

    assign req_ready  = !busy_reg;
    assign req_take   = req_valid && !busy_reg;
    assign advance    = busy_reg && (!valid_reg || line_ready);
    assign line_valid = valid_reg;
    assign line_word  = word_reg;
    assign cw         = rom_word(step_reg);

    always_comb
    begin
        case (cw.sel)
            SEL_ADDR:  body_byte = req_reg.address;
            SEL_V0_LO: body_byte = req_reg.value_first[7:0];
            SEL_V0_HI: body_byte = req_reg.value_first[15:8];
            SEL_V1_LO: body_byte = req_reg.value_second[7:0];
            SEL_V1_HI: body_byte = req_reg.value_second[15:8];
            SEL_V2_LO: body_byte = req_reg.value_third[7:0];
            SEL_V2_HI: body_byte = req_reg.value_third[15:8];
            default:   body_byte = req_reg.address;
        endcase
    end

    always_comb
    begin
        case (cw.src)
            SRC_START: src_byte = markers.start_marker;
            SRC_BODY:  src_byte = body_byte;
            SRC_STOP:  src_byte = markers.stop_marker;
            default:   src_byte = markers.stop_marker;
        endcase
    end

    always_comb
    begin
        case (cw.jmp)
            JMP_NONE:    take_jump = 1'b0;
            JMP_CNT_LT1: take_jump = (req_reg.value_count < 2'd1);
            JMP_CNT_LT2: take_jump = (req_reg.value_count < 2'd2);
            JMP_CNT_LT3: take_jump = (req_reg.value_count < 2'd3);
            default:     take_jump = 1'b0;
        endcase
    end

    assign reserved = cw.esc_chk && ((body_byte == markers.start_marker)
                                  || (body_byte == markers.stop_marker)
                                  || (body_byte == markers.escape_marker));

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        esc_next   = esc_reg;
        valid_next = valid_reg && !line_ready;
        word_next  = word_reg;
        if (req_take)
        begin
            busy_next = 1'b1;
            step_next = STEP_START;
            esc_next  = 1'b0;
        end
        else if (advance)
        begin
            valid_next = 1'b1;
            if (reserved && !esc_reg)
            begin
                word_next = '{line_byte: markers.escape_marker, frame_end: 1'b0};
                esc_next  = 1'b1;
            end
            else
            begin
                word_next = '{line_byte: src_byte, frame_end: cw.last};
                esc_next  = 1'b0;
                step_next = take_jump ? cw.target : cw.next;
                if (cw.last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= STEP_START;
            esc_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            esc_reg   <= esc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (req_take)
        begin
            req_reg <= req_word;
        end
    end

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> busy_reg && step_reg == STEP_START && !esc_reg)
        else $error("request not started at first step");

    a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> valid_reg && word_reg.line_byte == markers.escape_marker
                    && !word_reg.frame_end)
        else $error("escape flag set without escape word held");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !esc_reg)
        else $error("escape flag left set while idle");

    a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cw.last |=> !busy_reg && valid_reg && word_reg.frame_end)
        else $error("stop step did not close the frame");

endmodule
`default_nettype wire
